// ===== rtl/core/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants of the RPN stack evaluator
// Token and result beat layouts, code enums and stack sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned NumW       = 31;
  localparam int unsigned CountW     = 5;
  localparam int unsigned SpW        = $clog2(StackDepth + 1);
  localparam int unsigned AddrW      = $clog2(StackDepth);

  typedef enum logic [1:0] {
    KIND_NUMBER  = 2'd0,
    KIND_OPER    = 2'd1,
    KIND_END     = 2'd2,
    KIND_INVALID = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FEW      = 3'd1,
    ST_DIVZERO  = 3'd2,
    ST_INVALID  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_BADCOUNT = 3'd5
  } status_e;

  typedef struct packed {
    kind_e           kind;
    logic [NumW-1:0] number_value;
    op_e             op;
  } rpn_in_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  top_value;
    logic [CountW-1:0]        stack_count;
    logic                     done_res;
  } rpn_out_t;

  typedef struct packed {
    logic             start;
    op_e              op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpn_ram.sv =====
// ----------------------------------------------------------------------------
// rpn_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rpn_alu.sv =====
// ----------------------------------------------------------------------------
// rpn_alu: shared arithmetic unit of the RPN evaluator
// Add, subtract and multiply finish in the cycle after start; divide runs a
// restoring divider one quotient bit per cycle, then fixes the sign.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rpn_pkg::alu_req_t req_i,
  output rpn_pkg::alu_rsp_t      rsp_o
);

  import rpn_pkg::*;

  localparam int unsigned CntW = $clog2(DataW);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX
  } alu_state_e;

  alu_state_e       state_q;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] dvs_q;
  logic             neg_q;
  logic [DataW-1:0] res_q;
  logic             done_q;

  logic [DataW:0]   shifted;
  logic             fits;
  logic [DataW:0]   diff;
  logic [DataW-1:0] mag_a;
  logic [DataW-1:0] mag_b;
  logic [DataW-1:0] quick;

  always_comb begin
    mag_a   = req_i.a[DataW-1] ? (~req_i.a + DataW'(1)) : req_i.a;
    mag_b   = req_i.b[DataW-1] ? (~req_i.b + DataW'(1)) : req_i.b;
    shifted = {rem_q, quo_q[DataW-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = shifted >= {1'b0, dvs_q};
    unique case (req_i.op)
      OP_ADD:  quick = req_i.a + req_i.b;
      OP_SUB:  quick = req_i.a - req_i.b;
      OP_MUL:  quick = req_i.a * req_i.b;
      default: quick = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dvs_q   <= '0;
      neg_q   <= 1'b0;
      res_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            if (req_i.op == OP_DIV) begin
              rem_q   <= '0;
              quo_q   <= mag_a;
              dvs_q   <= mag_b;
              neg_q   <= req_i.a[DataW-1] ^ req_i.b[DataW-1];
              cnt_q   <= '0;
              state_q <= A_DIV;
            end else begin
              res_q  <= quick;
              done_q <= 1'b1;
            end
          end
        end
        A_DIV: begin
          // one quotient bit per cycle, shifted into the dividend register
          rem_q <= fits ? diff[DataW-1:0] : shifted[DataW-1:0];
          quo_q <= {quo_q[DataW-2:0], fits};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(DataW - 1)) begin
            state_q <= A_FIX;
          end
        end
        A_FIX: begin
          res_q   <= neg_q ? (~quo_q + DataW'(1)) : quo_q;
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/rpn_stack_evaluator.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: postfix integer expression evaluator
// Takes one token per beat and returns one result beat per token, keeping
// the operand stack in a small RAM with the top entry cached in a register.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------
//  token   | in        | in_valid_i / in_ready_o | in_data_i  (rpn_in_t)
//  result  | out       | out_valid_o/out_ready_i | out_data_o (rpn_out_t)
//
//  A token occupies the block from acceptance until its result is loaded
//  into the output register: number, end, invalid, failing and error-pending
//  tokens only execute and emit; other operators also read the lower operand
//  and wait for the shared unit (restoring divider and sign fix for divide).
//  The output register lets a new token enter while the last result waits.
//  Reset clears the stack pointer, the sticky error and all control state;
//  stack entries are undefined until pushed. A stalled result channel holds
//  the sequencer in its emit state until the output register frees up.
//
`default_nettype none

module rpn_stack_evaluator (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rpn_pkg::rpn_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output rpn_pkg::rpn_out_t     out_data_o
);

  import rpn_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_ALU,
    S_EMIT
  } seq_state_e;

  seq_state_e       state_q;
  rpn_in_t          tok_q;
  rpn_out_t         res_q;
  rpn_out_t         out_q;
  logic             out_valid_q;
  logic [SpW-1:0]   sp_q;
  status_e          err_q;
  logic [DataW-1:0] top_q;

  logic             push_ok;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [DataW-1:0] ram_rdata;
  logic [DataW-1:0] cur_top;
  logic [DataW-1:0] push_val;
  rpn_out_t         exec_res;
  status_e          exec_err;
  logic             exec_alu;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  // Take tokens only between items; the output register decouples the sides.
  assign in_ready_o = (state_q == S_IDLE);

  assign cur_top  = (sp_q == '0) ? '0 : top_q;
  assign push_val = {1'b0, tok_q.number_value};
  assign push_ok  = (state_q == S_EXEC) && (tok_q.kind == KIND_NUMBER) &&
                    (err_q == ST_OK) && (sp_q < SpW'(StackDepth));

  // Decode the held token: result beat, next sticky error, and whether the
  // operator goes to the shared unit.
  always_comb begin
    exec_res             = '0;
    exec_res.status      = err_q;
    exec_res.top_value   = cur_top;
    exec_res.stack_count = CountW'(sp_q);
    exec_err             = err_q;
    exec_alu             = 1'b0;
    if (tok_q.kind == KIND_END) begin
      // close the expression: report, then clear stack and error
      exec_res.done_res    = 1'b1;
      exec_res.stack_count = '0;
      exec_res.top_value   = '0;
      exec_err             = ST_OK;
      if (err_q != ST_OK) begin
        exec_res.status = err_q;
      end else if (sp_q != SpW'(1)) begin
        exec_res.status = ST_BADCOUNT;
      end else begin
        exec_res.status    = ST_OK;
        exec_res.top_value = top_q;
      end
    end else if (err_q != ST_OK) begin
      // error pending: hold the stack, report sticky error
    end else if (tok_q.kind == KIND_INVALID) begin
      exec_err        = ST_INVALID;
      exec_res.status = ST_INVALID;
    end else if (tok_q.kind == KIND_NUMBER) begin
      if (sp_q < SpW'(StackDepth)) begin
        exec_res.top_value   = push_val;
        exec_res.stack_count = CountW'(sp_q + SpW'(1));
      end else begin
        exec_err        = ST_OVERFLOW;
        exec_res.status = ST_OVERFLOW;
      end
    end else if (sp_q < SpW'(2)) begin
      exec_err        = ST_FEW;
      exec_res.status = ST_FEW;
    end else if ((tok_q.op == OP_DIV) && (top_q == '0)) begin
      exec_err        = ST_DIVZERO;
      exec_res.status = ST_DIVZERO;
    end else begin
      // lower operand read is in flight
      exec_alu = 1'b1;
    end
  end

  // Stack RAM: push writes at the pointer, an operator result overwrites
  // the lower operand's slot. Read always targets the second entry.
  always_comb begin
    ram_we    = push_ok || ((state_q == S_ALU) && alu_rsp.done);
    ram_waddr = push_ok ? AddrW'(sp_q) : AddrW'(sp_q - SpW'(2));
    ram_wdata = push_ok ? push_val : alu_rsp.result;
    ram_raddr = AddrW'(sp_q - SpW'(2));
  end

  assign alu_req.start = (state_q == S_READ);
  assign alu_req.op    = tok_q.op;
  assign alu_req.a     = ram_rdata;
  assign alu_req.b     = top_q;

  rpn_ram #(
    .Width (DataW),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rpn_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tok_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      sp_q        <= '0;
      err_q       <= ST_OK;
      top_q       <= '0;
    end else begin
      // drop the result once taken, unless the emit state replaces it
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            tok_q   <= in_data_i;
            state_q <= S_EXEC;
          end
        end

        S_EXEC: begin
          res_q   <= exec_res;
          err_q   <= exec_err;
          state_q <= exec_alu ? S_READ : S_EMIT;
          if (tok_q.kind == KIND_END) begin
            sp_q <= '0;
          end else if (push_ok) begin
            top_q <= push_val;
            sp_q  <= sp_q + SpW'(1);
          end
        end

        S_READ: begin
          state_q <= S_ALU;
        end

        S_ALU: begin
          if (alu_rsp.done) begin
            top_q             <= alu_rsp.result;
            sp_q              <= sp_q - SpW'(1);
            res_q.status      <= ST_OK;
            res_q.top_value   <= alu_rsp.result;
            res_q.stack_count <= CountW'(sp_q - SpW'(1));
            res_q.done_res    <= 1'b0;
            state_q           <= S_EMIT;
          end
        end

        S_EMIT: begin
          // advance only when the output register is free or being emptied
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The shared unit only answers while the sequencer waits for it.
  a_alu_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> (state_q == S_ALU))
    else $error("ALU result outside wait state");

  // A divide is never launched with a zero divisor.
  a_no_div_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_READ) && (tok_q.op == OP_DIV)) |-> (top_q != '0))
    else $error("divide issued with zero divisor");

  // The stack pointer never passes the stack depth.
  a_sp_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SpW'(StackDepth))
    else $error("stack pointer beyond depth");

  // An accepted token starts execution on the next cycle.
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted token not executed");

endmodule

`default_nettype wire
